### hdl/fixed_block_free_list_allocator_top_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the block free list allocator
// Concurrent assertion wrappers clocked on clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FBA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator assertion failed");
`define FBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator assertion failed");
`else
`define FBA_ASSERT(lbl, ante, cons)
`define FBA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hdl/fbfla_pkg.sv
// -----------------------------------------------------------------------------
// Block free list allocator package
// Shared constants, codes and control types of the allocator.
// -----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int IDX_W          = 12;
  localparam int CNT_W          = 13;
  localparam int BYTES_W        = 17;
  localparam int OFS_W          = 28;
  localparam int LINK_W         = 12;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;
  localparam int IN_TDATA_W     = 16;
  localparam int IN_TUSER_W     = 1;
  localparam int OUT_TDATA_W    = 88;
  localparam int OUT_TUSER_W    = 2;

  localparam logic [BYTES_W-1:0] PTR_BYTES = 17'd8;
  localparam logic [BYTES_W-1:0] SIZE_CAP  = 17'd65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_DISABLED = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0,
    REG_COUNT  = 2'd1,
    REG_BYTES  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

### hdl/fixed_block_free_list_allocator_top.sv
// -----------------------------------------------------------------------------
// Fixed block free list allocator, top level
// Channel       | Dir | Handshake                    | Content
// s_axis        | in  | s_axis_tvalid/s_axis_tready  | allocate or free request
// m_axis        | out | m_axis_tvalid/m_axis_tready  | status and pool figures
// cfg           | in  | cfg_we_i                     | enable, count, block size
//
// For each request the head link is read from the link memory in the accept
// cycle and the free list is updated when the request executes.
// A finished result waits in the output register while the next request is
// taken; execution stalls only while that register is still full.
// Reset clears the pool state; the link memory is not cleared.
// -----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
  parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: block_index[11:0], zero padding.
  input  logic [fbfla_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: operation.
  input  logic [fbfla_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: granted_index[11:0], byte_offset[39:12],
  // used_count[52:40], total_count[65:53], size_bytes[82:66], zero padding.
  output logic [fbfla_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [fbfla_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import fbfla_pkg::*;

  localparam int PAD_W = OUT_TDATA_W - IDX_W - OFS_W - 2 * CNT_W - BYTES_W;

  ctrl_cmd_t          cmd;
  dp_status_t         dp_status;
  logic [1:0]         res_status;
  logic [IDX_W-1:0]   res_granted;
  logic [OFS_W-1:0]   res_offset;
  logic [CNT_W-1:0]   res_used;
  logic [CNT_W-1:0]   res_total;
  logic [BYTES_W-1:0] res_size;

  fbfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  fbfla_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .in_op_i       (s_axis_tuser[0]),
    .in_index_i    (s_axis_tdata[IDX_W-1:0]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_status_o  (res_status),
    .out_granted_o (res_granted),
    .out_offset_o  (res_offset),
    .out_used_o    (res_used),
    .out_total_o   (res_total),
    .out_size_o    (res_size)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, res_size, res_total, res_used,
                         res_offset, res_granted};
  assign m_axis_tuser = res_status;

endmodule

### hdl/fbfla_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// -----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fbfla_ctrl.sv
// -----------------------------------------------------------------------------
// Allocator controller
// Two-state sequencer: take an item, then execute it once the result slot
// is free.
// -----------------------------------------------------------------------------
module fbfla_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  fbfla_pkg::dp_status_t  status_i,
  output fbfla_pkg::ctrl_cmd_t   cmd_o
);
  import fbfla_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!status_i.out_full) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = !status_i.out_full;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### hdl/fbfla_dp.sv
// -----------------------------------------------------------------------------
// Allocator datapath
// Configuration registers, free list state, link memory and result register.
// -----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_top_defines.svh"

module fbfla_dp #(
  parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  fbfla_pkg::ctrl_cmd_t              cmd_i,
  output fbfla_pkg::dp_status_t             status_o,
  input  logic                              in_op_i,
  input  logic [fbfla_pkg::IDX_W-1:0]       in_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        out_status_o,
  output logic [fbfla_pkg::IDX_W-1:0]       out_granted_o,
  output logic [fbfla_pkg::OFS_W-1:0]       out_offset_o,
  output logic [fbfla_pkg::CNT_W-1:0]       out_used_o,
  output logic [fbfla_pkg::CNT_W-1:0]       out_total_o,
  output logic [fbfla_pkg::BYTES_W-1:0]     out_size_o
);
  import fbfla_pkg::*;

  localparam int AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CWM  = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = (CWM > CNT_W) ? CWM : CNT_W;
  localparam int PW   = CW + BYTES_W;

  logic               en_q, en_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTES_W-1:0] bytes_q, bytes_d;
  logic               clear_pool;

  logic               op_q;
  logic [IDX_W-1:0]   idx_q;

  logic [LINK_W-1:0]  head_q, head_d;
  logic               nonempty_q, nonempty_d;
  logic [CW-1:0]      fresh_q, fresh_d;
  logic [CW-1:0]      used_q, used_d;

  logic [CW-1:0]      total_w;
  logic [BYTES_W-1:0] size_w;
  logic               disabled_w;

  logic               ram_we;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_W-1:0]  ram_rdata;

  logic [1:0]         res_status;
  logic [CW-1:0]      res_granted;
  logic [PW-1:0]      res_prod;

  logic               m_valid_q;
  logic [1:0]         m_status_q;
  logic [IDX_W-1:0]   m_granted_q;
  logic [OFS_W-1:0]   m_offset_q;
  logic [CNT_W-1:0]   m_used_q;
  logic [CNT_W-1:0]   m_total_q;
  logic [BYTES_W-1:0] m_size_q;

  // Configuration registers; any write to a known register restarts the pool.
  always_comb begin
    en_d       = en_q;
    cnt_d      = cnt_q;
    bytes_d    = bytes_q;
    clear_pool = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: begin
          en_d       = cfg_data_i[0];
          clear_pool = 1'b1;
        end
        REG_COUNT: begin
          cnt_d      = cfg_data_i[CNT_W-1:0];
          clear_pool = 1'b1;
        end
        REG_BYTES: begin
          bytes_d    = cfg_data_i[BYTES_W-1:0];
          clear_pool = 1'b1;
        end
        default: clear_pool = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      cnt_q   <= 13'd4096;
      bytes_q <= PTR_BYTES;
    end else begin
      en_q    <= en_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
    end
  end

  assign total_w = ((cnt_q == '0) || (CW'(cnt_q) > CW'(MAX_BLOCKS))) ?
                   CW'(MAX_BLOCKS) : CW'(cnt_q);
  assign size_w  = (bytes_q < PTR_BYTES) ? PTR_BYTES :
                   (bytes_q > SIZE_CAP) ? SIZE_CAP : bytes_q;
  assign disabled_w = !en_q || (bytes_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      idx_q <= in_index_i;
    end
  end

  // The head entry is read as the item is taken and used when it executes.
  fbfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(idx_q)),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.load),
    .raddr_i (AW'(head_q)),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = nonempty_q ? head_q : idx_q;

  always_comb begin
    head_d      = head_q;
    nonempty_d  = nonempty_q;
    fresh_d     = fresh_q;
    used_d      = used_q;
    ram_we      = 1'b0;
    res_status  = ST_OK;
    res_granted = '0;
    if (disabled_w) begin
      res_status = ST_DISABLED;
    end else if (op_q == OP_ALLOC) begin
      if (nonempty_q) begin
        res_granted = CW'(head_q);
        if (ram_rdata == head_q) begin
          nonempty_d = 1'b0;
        end else begin
          head_d = ram_rdata;
        end
        if (used_q < total_w) used_d = used_q + CW'(1);
      end else if (fresh_q < total_w) begin
        res_granted = fresh_q;
        fresh_d     = fresh_q + CW'(1);
        if (used_q < total_w) used_d = used_q + CW'(1);
      end else begin
        res_status = ST_EMPTY;
      end
    end else begin
      if (CW'(idx_q) >= total_w) begin
        res_status = ST_RANGE;
      end else begin
        ram_we     = cmd_i.exec;
        head_d     = idx_q;
        nonempty_d = 1'b1;
        if (used_q != '0) used_d = used_q - CW'(1);
      end
    end
  end

  assign res_prod = PW'(res_granted) * PW'(size_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      nonempty_q <= 1'b0;
      fresh_q    <= '0;
      used_q     <= '0;
    end else if (clear_pool) begin
      head_q     <= '0;
      nonempty_q <= 1'b0;
      fresh_q    <= '0;
      used_q     <= '0;
    end else if (cmd_i.exec) begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      fresh_q    <= fresh_d;
      used_q     <= used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      m_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      m_status_q  <= res_status;
      m_granted_q <= disabled_w ? '0 : IDX_W'(res_granted);
      m_offset_q  <= (res_status == ST_OK) ? OFS_W'(res_prod) : '0;
      m_used_q    <= disabled_w ? '0 : CNT_W'(used_d);
      m_total_q   <= disabled_w ? '0 : CNT_W'(total_w);
      m_size_q    <= disabled_w ? '0 : size_w;
    end
  end

  assign status_o.out_full = m_valid_q && !out_ready_i;
  assign out_valid_o       = m_valid_q;
  assign out_status_o      = m_status_q;
  assign out_granted_o     = m_granted_q;
  assign out_offset_o      = m_offset_q;
  assign out_used_o        = m_used_q;
  assign out_total_o       = m_total_q;
  assign out_size_o        = m_size_q;

  `FBA_ASSERT(a_exec_room, cmd_i.exec, !m_valid_q || out_ready_i)
  `FBA_ASSERT_NXT(a_exec_shows, cmd_i.exec, m_valid_q)
  `FBA_ASSERT(a_used_cap, 1'b1, used_q <= total_w)
  `FBA_ASSERT(a_fresh_cap, 1'b1, fresh_q <= total_w)

endmodule
